FILE: design/srpt_pkg.sv
// Shared types and constants for the source-route parent table.
// Used by source_route_parent_table and srpt_checker; depends on nothing.
`timescale 1ns / 1ps

package srpt_pkg;

    localparam int ADDR_W     = 8;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int EPOCH_W    = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOOP     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

    typedef struct packed {
        logic [EPOCH_W-1:0] mark;
        logic [ADDR_W-1:0]  parent;
    } tbl_entry_t;

    typedef enum logic [3:0] {
        ST_WIPE_RD,
        ST_WIPE_WR,
        ST_IDLE,
        ST_GET_RD,
        ST_GET_OUT,
        ST_FIND_RD,
        ST_FIND_EVAL,
        ST_FAIL_OUT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage

FILE: design/source_route_parent_table.sv
// Top level of the source-route parent table: command sequencer, table and route buffer.
// Depends on srpt_pkg and srpt_ram.
`timescale 1ns / 1ps

// The block keeps the parent of every node address in a synchronous table memory, and each
// entry also carries a walk mark used to detect loops in one pass. After reset the block
// sweeps the table to zero and holds s_tready low meanwhile. An update word gives no result.
// A get-parent word reads the table and then gives its result. A find-route word walks hop by
// hop, every hop being one table read followed by one evaluate and write-back, and then emits
// each hop from the route buffer, one buffer read and one output load per hop; a failed walk
// gives its single result from the fail state after the failing hop. Once every 255
// find-route words that start a walk, the marks are swept again, keeping the parents, before
// that word walks. Words are taken one at a time, but the next one is accepted while the
// previous result still waits in the output register.
module source_route_parent_table #(
    parameter int TABLE_NODES = 256,
    parameter int MAX_ROUTE   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // cfg_wdata: sink_address
    input  logic                              cfg_we,
    input  logic [srpt_pkg::ADDR_W-1:0]       cfg_wdata,
    // s_tdata: command [1:0], node_address [9:2], parent_address [17:10], zeros above
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srpt_pkg::IN_DATA_W-1:0]    s_tdata,
    // m_tdata: hop_address [7:0], status [10:8], zeros above
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [srpt_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    localparam int TBL_DEPTH = (TABLE_NODES < 256) ? TABLE_NODES : 256;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int BW        = $clog2(MAX_ROUTE);
    localparam int LW        = $clog2(MAX_ROUTE + 1);
    localparam int ENT_W     = $bits(srpt_pkg::tbl_entry_t);

    srpt_pkg::state_t state_reg, state_next;

    logic [srpt_pkg::ADDR_W-1:0]   sink_reg;
    logic [srpt_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [LW-1:0]                 len_reg, len_next;
    logic [BW-1:0]                 emit_idx_reg, emit_idx_next;
    logic [srpt_pkg::EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [AW-1:0]                 wipe_idx_reg, wipe_idx_next;
    logic                          wipe_keep_reg, wipe_keep_next;
    logic [srpt_pkg::STATUS_W-1:0] fail_reg, fail_next;

    logic                          m_valid_reg;
    logic [srpt_pkg::ADDR_W-1:0]   m_hop_reg, m_hop_next;
    logic [srpt_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic                          m_last_reg, m_last_next;
    logic                          out_load;
    logic                          out_free;

    logic [srpt_pkg::CMD_W-1:0]    in_cmd;
    logic [srpt_pkg::ADDR_W-1:0]   in_node;
    logic [srpt_pkg::ADDR_W-1:0]   in_parent;
    logic                          in_accept;
    logic                          in_node_ok;
    logic                          addr_ok;

    logic                          tbl_we, tbl_re;
    logic [AW-1:0]                 tbl_waddr, tbl_raddr;
    srpt_pkg::tbl_entry_t          tbl_wdata, tbl_rdata;
    logic [ENT_W-1:0]              tbl_rdata_raw;
    logic [srpt_pkg::ADDR_W-1:0]   ent_parent;

    logic                          buf_we, buf_re;
    logic [BW-1:0]                 buf_waddr, buf_raddr;
    logic [srpt_pkg::ADDR_W-1:0]   buf_rdata;

    assign in_cmd    = s_tdata[1:0];
    assign in_node   = s_tdata[9:2];
    assign in_parent = s_tdata[17:10];
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == srpt_pkg::ST_IDLE);

    assign in_node_ok = (32'(in_node) < 32'(TABLE_NODES));
    assign addr_ok    = (32'(addr_reg) < 32'(TABLE_NODES));
    assign out_free   = !m_valid_reg || m_tready;

    assign tbl_rdata  = srpt_pkg::tbl_entry_t'(tbl_rdata_raw);
    assign ent_parent = addr_ok ? tbl_rdata.parent : '0;

    srpt_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (ENT_W)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (ENT_W'(tbl_wdata)),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata_raw)
    );

    srpt_ram #(
        .DEPTH (MAX_ROUTE),
        .WIDTH (srpt_pkg::ADDR_W)
    ) u_route (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (addr_reg),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srpt_pkg::ST_WIPE_RD;
            sink_reg      <= 8'd1;
            epoch_reg     <= '0;
            wipe_idx_reg  <= '0;
            wipe_keep_reg <= 1'b0;
            len_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            wipe_idx_reg  <= wipe_idx_next;
            wipe_keep_reg <= wipe_keep_next;
            len_reg       <= len_next;
            if (cfg_we) begin
                sink_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        emit_idx_reg <= emit_idx_next;
        fail_reg     <= fail_next;
        m_hop_reg    <= m_hop_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        emit_idx_next  = emit_idx_reg;
        epoch_next     = epoch_reg;
        wipe_idx_next  = wipe_idx_reg;
        wipe_keep_next = wipe_keep_reg;
        fail_next      = fail_reg;
        m_hop_next     = m_hop_reg;
        m_status_next  = m_status_reg;
        m_last_next    = m_last_reg;
        out_load       = 1'b0;
        tbl_we         = 1'b0;
        tbl_waddr      = addr_reg[AW-1:0];
        tbl_wdata      = '0;
        tbl_re         = 1'b0;
        tbl_raddr      = addr_reg[AW-1:0];
        buf_we         = 1'b0;
        buf_waddr      = len_reg[BW-1:0];
        buf_re         = 1'b0;
        buf_raddr      = emit_idx_reg;

        case (state_reg)
            srpt_pkg::ST_WIPE_RD: begin
                tbl_re     = 1'b1;
                tbl_raddr  = wipe_idx_reg;
                state_next = srpt_pkg::ST_WIPE_WR;
            end
            srpt_pkg::ST_WIPE_WR: begin
                tbl_we           = 1'b1;
                tbl_waddr        = wipe_idx_reg;
                tbl_wdata.mark   = '0;
                tbl_wdata.parent = wipe_keep_reg ? tbl_rdata.parent : '0;
                wipe_idx_next    = wipe_idx_reg + AW'(1);
                if (wipe_idx_reg == AW'(TBL_DEPTH - 1)) begin
                    wipe_idx_next = '0;
                    if (wipe_keep_reg) begin
                        epoch_next = srpt_pkg::EPOCH_W'(1);
                        state_next = srpt_pkg::ST_FIND_RD;
                    end else begin
                        state_next = srpt_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = srpt_pkg::ST_WIPE_RD;
                end
            end
            srpt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    addr_next = in_node;
                    len_next  = '0;
                    case (in_cmd)
                        srpt_pkg::CMD_UPDATE: begin
                            tbl_we           = in_node_ok;
                            tbl_waddr        = in_node[AW-1:0];
                            tbl_wdata.mark   = '0;
                            tbl_wdata.parent = in_parent;
                        end
                        srpt_pkg::CMD_GET: begin
                            state_next = srpt_pkg::ST_GET_RD;
                        end
                        srpt_pkg::CMD_FIND: begin
                            if (in_node == sink_reg) begin
                                fail_next  = srpt_pkg::STATUS_EMPTY;
                                state_next = srpt_pkg::ST_FAIL_OUT;
                            end else if (epoch_reg == '1) begin
                                wipe_keep_next = 1'b1;
                                wipe_idx_next  = '0;
                                state_next     = srpt_pkg::ST_WIPE_RD;
                            end else begin
                                epoch_next = epoch_reg + srpt_pkg::EPOCH_W'(1);
                                state_next = srpt_pkg::ST_FIND_RD;
                            end
                        end
                        default: begin
                            state_next = srpt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            srpt_pkg::ST_GET_RD: begin
                tbl_re     = 1'b1;
                state_next = srpt_pkg::ST_GET_OUT;
            end
            srpt_pkg::ST_GET_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_hop_next    = ent_parent;
                    m_status_next = (ent_parent != '0) ? srpt_pkg::STATUS_OK
                                                       : srpt_pkg::STATUS_MISSING;
                    m_last_next   = 1'b1;
                    state_next    = srpt_pkg::ST_IDLE;
                end
            end
            srpt_pkg::ST_FIND_RD: begin
                tbl_re     = 1'b1;
                state_next = srpt_pkg::ST_FIND_EVAL;
            end
            srpt_pkg::ST_FIND_EVAL: begin
                if (addr_ok && (tbl_rdata.mark == epoch_reg)) begin
                    fail_next  = srpt_pkg::STATUS_LOOP;
                    state_next = srpt_pkg::ST_FAIL_OUT;
                end else if (len_reg >= LW'(MAX_ROUTE)) begin
                    fail_next  = srpt_pkg::STATUS_TOO_LONG;
                    state_next = srpt_pkg::ST_FAIL_OUT;
                end else begin
                    buf_we           = 1'b1;
                    len_next         = len_reg + LW'(1);
                    tbl_we           = addr_ok;
                    tbl_wdata.mark   = epoch_reg;
                    tbl_wdata.parent = tbl_rdata.parent;
                    if (ent_parent == '0) begin
                        fail_next  = srpt_pkg::STATUS_MISSING;
                        state_next = srpt_pkg::ST_FAIL_OUT;
                    end else if (ent_parent == sink_reg) begin
                        emit_idx_next = len_reg[BW-1:0];
                        state_next    = srpt_pkg::ST_EMIT_RD;
                    end else begin
                        addr_next  = ent_parent;
                        state_next = srpt_pkg::ST_FIND_RD;
                    end
                end
            end
            srpt_pkg::ST_FAIL_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_hop_next    = '0;
                    m_status_next = fail_reg;
                    m_last_next   = 1'b1;
                    len_next      = '0;
                    state_next    = srpt_pkg::ST_IDLE;
                end
            end
            srpt_pkg::ST_EMIT_RD: begin
                buf_re     = 1'b1;
                state_next = srpt_pkg::ST_EMIT_OUT;
            end
            srpt_pkg::ST_EMIT_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_hop_next    = buf_rdata;
                    m_status_next = srpt_pkg::STATUS_OK;
                    m_last_next   = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0) begin
                        state_next = srpt_pkg::ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg - BW'(1);
                        state_next    = srpt_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = srpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_hop_reg};
    assign m_tlast  = m_last_reg;

endmodule

FILE: design/srpt_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the parent table and the route buffer; depends on nothing.
`timescale 1ns / 1ps

module srpt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/srpt_checker.sv
// Port-level checks for the source-route parent table, attached to the top level by bind.
// Depends on srpt_pkg and source_route_parent_table.
`timescale 1ns / 1ps

module srpt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [srpt_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    // A stalled result word must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Any failure or empty-route status is the only word of its command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[10:8] != srpt_pkg::STATUS_OK) |-> m_tlast)
        else $error("non-ok status without last");

    // Failure and empty-route words carry no hop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[10:8] != srpt_pkg::STATUS_OK) |-> (m_tdata[7:0] == 8'd0))
        else $error("non-ok status with a hop address");

    // Reset empties the output and starts the table sweep, so nothing is accepted.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("block not quiet after reset");

endmodule

bind source_route_parent_table srpt_checker u_srpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
